// File: rtl/core/token_bucket_limiter_core_assert.svh
// Assertion macros used by the token bucket limiter checker.
`ifndef TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBKT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tbkt_pkg.sv
// Shared widths, operation codes and helper functions of the token bucket limiter.
`default_nettype none

package tbkt_pkg;

    // Field widths of the stream channels.
    localparam int FUNC_W     = 2;
    localparam int AMOUNT_W   = 40;
    localparam int NOW_W      = 48;
    localparam int WAIT_W     = 48;
    localparam int IN_DATA_W  = ((AMOUNT_W + NOW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + WAIT_W + 7) / 8) * 8;

    // Arithmetic sizing.
    localparam int RATE_BITS = 40;
    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 16;
    localparam int TOK_W     = 64;
    localparam int USEC_W    = 20;

    // Product of the shift-add multiplier: elapsed times rate, or deficit times 10^6.
    localparam int PROD_W = (TIME_BITS + RATE_BITS > TOK_W + USEC_W) ?
                            (TIME_BITS + RATE_BITS) : (TOK_W + USEC_W);
    // Dividend of the restoring divider, with room for the fraction shift.
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int DVSR_W = RATE_BITS + FRAC_BITS;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [WAIT_W-1:0] MIN_WAIT_US  = WAIT_W'(100);
    localparam logic [TOK_W-1:0]  BURST_FLOOR  = TOK_W'(65536) << FRAC_BITS;
    localparam logic [TOK_W-1:0]  TOK_MIN      = {1'b1, {(TOK_W - 1){1'b0}}};

    // Operation codes carried in tuser.
    localparam logic [FUNC_W-1:0] FUNC_TAKE     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEBIT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_RATE = 2'd2;

    typedef logic [TOK_W-1:0]     t_tok;
    typedef logic [RATE_BITS-1:0] t_rate;

    // Burst limit: the larger of a quarter second of tokens and 64 KiB.
    function automatic t_tok burst_of(input t_rate rate);
        t_tok quarter;
        quarter = (TOK_W'(rate) << FRAC_BITS) >> 2;
        return (quarter > BURST_FLOOR) ? quarter : BURST_FLOOR;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/token_bucket_limiter_core.sv
// Token bucket limiter core with a bit-serial multiplier and divider.
//
// Input channel (s): one operation per transfer. tuser carries the operation
// (take, debit, set rate); tdata carries the byte count or new rate and the
// microsecond timestamp. Output channel (m): one result per operation, the
// grant flag and, for a refused take, the wait time in microseconds.
// The block works on one operation at a time. A take or debit with limiting
// off, or an unused code, goes from idle straight to the done state; an
// operation with no elapsed time to refill passes through the operation step
// first. A refill runs the shift-add multiplier over the rate bits, the
// restoring divider over the dividend bits and a capping step before the
// operation step. A refused take then runs the multiplier over the 20 bits
// of 10^6 and the divider again. The core is ready for the next operation as
// soon as the result is registered, and the divider's one bit per cycle sets
// most of the latency.
// A synchronous active-low reset empties the bucket, turns limiting off and
// drops any pending result. When the receiver stalls, the finished result
// stays in the output register, the next operation is still taken and
// computed, and its result waits until the output register frees up.
`default_nettype none

module token_bucket_limiter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: amount [39:0], now_us [87:40]
    input  logic [tbkt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: func [1:0]
    input  logic [tbkt_pkg::FUNC_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: granted [0], wait_us [48:1], zero fill above
    output logic [tbkt_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import tbkt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_REFILL = 3'd3;
    localparam logic [2:0] ST_OP     = 3'd4;
    localparam logic [2:0] ST_WAIT   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Control and bucket state.
    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    t_tok                r_tok, n_tok;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic                r_seen, n_seen;
    t_rate               r_rate, n_rate;

    // Operation and datapath registers.
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [AMOUNT_W-1:0] r_amount, n_amount;
    logic                r_wait_phase, n_wait_phase;
    t_tok                r_mcand, n_mcand;
    t_rate               r_mplier, n_mplier;
    logic [DVD_W-1:0]    r_wide, n_wide;
    logic [DVSR_W-1:0]   r_dvsr, n_dvsr;
    logic [DVSR_W-1:0]   r_rem, n_rem;
    t_tok                r_quo, n_quo;
    logic                r_ovf, n_ovf;
    logic                r_res_granted, n_res_granted;
    logic [WAIT_W-1:0]   r_res_wait, n_res_wait;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Datapath helpers.
    logic [FUNC_W-1:0]    in_func;
    logic [AMOUNT_W-1:0]  in_amount;
    logic [TIME_BITS-1:0] in_now;
    logic                 rate_on;
    logic                 does_refill;
    logic [DVD_W-1:0]     mul_sum;
    logic [DVSR_W:0]      div_shift;
    logic                 div_ge;
    t_tok                 added;
    t_tok                 burst_cur;
    t_tok                 burst_new;
    logic [TOK_W+1:0]     refill_sum;
    t_tok                 need;
    logic [TOK_W:0]       deficit;
    logic [TOK_W:0]       debit_diff;
    logic [WAIT_W-1:0]    wait_val;

    assign in_func   = i_s_tuser;
    assign in_amount = i_s_tdata[AMOUNT_W-1:0];
    assign in_now    = TIME_BITS'(i_s_tdata[AMOUNT_W +: NOW_W]);
    assign rate_on   = (r_rate != '0);
    assign does_refill = (in_func == FUNC_SET_RATE) ||
                         (((in_func == FUNC_TAKE) || (in_func == FUNC_DEBIT)) && rate_on);

    // One shift-add step, multiplier taken MSB first.
    assign mul_sum = (r_wide << 1) + (r_mplier[RATE_BITS-1] ? DVD_W'(r_mcand) : '0);

    // One restoring division step.
    assign div_shift = {r_rem, r_wide[DVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, r_dvsr});

    // Refill sum, signed tokens plus unsigned added tokens.
    assign added      = r_ovf ? '1 : r_quo;
    assign burst_cur  = burst_of(r_rate);
    assign burst_new  = burst_of(RATE_BITS'(r_amount));
    assign refill_sum = {{2{r_tok[TOK_W-1]}}, r_tok} + {2'b00, added};

    // Take and debit arithmetic, one bit wider to see sign and overflow.
    assign need       = TOK_W'(r_amount) << FRAC_BITS;
    assign deficit    = {1'b0, need} - {r_tok[TOK_W-1], r_tok};
    assign debit_diff = {r_tok[TOK_W-1], r_tok} - {1'b0, need};

    // Wait time: saturate, round up, then apply the minimum.
    always_comb begin
        if (r_ovf || (r_quo[TOK_W-1:WAIT_W] != '0)) begin
            wait_val = '1;
        end else if ((r_rem != '0) && (r_quo[WAIT_W-1:0] != '1)) begin
            wait_val = r_quo[WAIT_W-1:0] + WAIT_W'(1);
        end else begin
            wait_val = r_quo[WAIT_W-1:0];
        end
        if (wait_val < MIN_WAIT_US) begin
            wait_val = MIN_WAIT_US;
        end
    end

    // Sequencer and next-state logic.
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_tok         = r_tok;
        n_last        = r_last;
        n_seen        = r_seen;
        n_rate        = r_rate;
        n_func        = r_func;
        n_amount      = r_amount;
        n_wait_phase  = r_wait_phase;
        n_mcand       = r_mcand;
        n_mplier      = r_mplier;
        n_wide        = r_wide;
        n_dvsr        = r_dvsr;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_ovf         = r_ovf;
        n_res_granted = r_res_granted;
        n_res_wait    = r_res_wait;
        n_out_data    = r_out_data;

        // Output register empties on a transfer.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_func        = in_func;
                    n_amount      = in_amount;
                    n_res_granted = 1'b1;
                    n_res_wait    = '0;
                    if (!does_refill) begin
                        n_state = ST_DONE;
                    end else begin
                        n_last = in_now;
                        n_seen = 1'b1;
                        if (r_seen && rate_on && (in_now > r_last)) begin
                            n_mcand      = TOK_W'(in_now - r_last);
                            n_mplier     = r_rate;
                            n_cnt        = CNT_W'(RATE_BITS);
                            n_wide       = '0;
                            n_wait_phase = 1'b0;
                            n_state      = ST_MUL;
                        end else begin
                            n_state = ST_OP;
                        end
                    end
                end
            end

            ST_MUL: begin
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    // Set up the divider for the product just formed.
                    if (r_wait_phase) begin
                        n_wide = mul_sum;
                        n_dvsr = DVSR_W'(r_rate) << FRAC_BITS;
                    end else begin
                        n_wide = mul_sum << FRAC_BITS;
                        n_dvsr = DVSR_W'(USEC_PER_SEC);
                    end
                    n_rem   = '0;
                    n_quo   = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = CNT_W'(DVD_W);
                    n_state = ST_DIV;
                end else begin
                    n_wide = mul_sum;
                end
            end

            ST_DIV: begin
                n_rem  = div_ge ? DVSR_W'(div_shift - {1'b0, r_dvsr}) : DVSR_W'(div_shift);
                n_quo  = {r_quo[TOK_W-2:0], div_ge};
                n_ovf  = r_ovf | r_quo[TOK_W-1];
                n_wide = r_wide << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = r_wait_phase ? ST_WAIT : ST_REFILL;
                end
            end

            ST_REFILL: begin
                // Cap the refilled level at the burst limit of the current rate.
                if ($signed(refill_sum) >= $signed({2'b00, burst_cur})) begin
                    n_tok = burst_cur;
                end else begin
                    n_tok = refill_sum[TOK_W-1:0];
                end
                n_state = ST_OP;
            end

            ST_OP: begin
                n_state = ST_DONE;
                case (r_func)
                    FUNC_TAKE: begin
                        if (deficit[TOK_W] || (deficit == '0)) begin
                            n_tok = debit_diff[TOK_W-1:0];
                        end else begin
                            n_mcand      = deficit[TOK_W-1:0];
                            n_mplier     = RATE_BITS'(USEC_PER_SEC) << (RATE_BITS - USEC_W);
                            n_cnt        = CNT_W'(USEC_W);
                            n_wide       = '0;
                            n_wait_phase = 1'b1;
                            n_state      = ST_MUL;
                        end
                    end
                    FUNC_DEBIT: begin
                        // Saturate at the most negative level.
                        if (debit_diff[TOK_W] != debit_diff[TOK_W-1]) begin
                            n_tok = TOK_MIN;
                        end else begin
                            n_tok = debit_diff[TOK_W-1:0];
                        end
                    end
                    FUNC_SET_RATE: begin
                        n_rate = RATE_BITS'(r_amount);
                        if ($signed(r_tok) > $signed(burst_new)) begin
                            n_tok = burst_new;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_WAIT: begin
                n_res_granted = 1'b0;
                n_res_wait    = wait_val;
                n_state       = ST_DONE;
            end

            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_res_wait, r_res_granted});
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and bucket state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_tok       <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_rate      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_tok       <= n_tok;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_rate      <= n_rate;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_amount      <= n_amount;
        r_wait_phase  <= n_wait_phase;
        r_mcand       <= n_mcand;
        r_mplier      <= n_mplier;
        r_wide        <= n_wide;
        r_dvsr        <= n_dvsr;
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_ovf         <= n_ovf;
        r_res_granted <= n_res_granted;
        r_res_wait    <= n_res_wait;
        r_out_data    <= n_out_data;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/core/tbkt_checker.sv
// Port-level checker for the token bucket limiter core, bound to the core.
`default_nettype none

`include "token_bucket_limiter_core_assert.svh"

module tbkt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           o_s_tready,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [tbkt_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import tbkt_pkg::*;

    logic              res_granted;
    logic [WAIT_W-1:0] res_wait;

    assign res_granted = o_m_tdata[0];
    assign res_wait    = o_m_tdata[WAIT_W:1];

    // A stalled result stays offered and unchanged.
    `TBKT_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    // The core works on one operation at a time.
    `TBKT_ASSERT_NEXT(a_busy_after_in, i_s_tvalid && o_s_tready, !o_s_tready, "second operation taken while busy")
    // A granted operation reports no wait.
    `TBKT_ASSERT_SAME(a_grant_no_wait, o_m_tvalid && res_granted, res_wait == '0, "granted result with nonzero wait")
    // A refused take reports at least the minimum wait.
    `TBKT_ASSERT_SAME(a_refuse_min_wait, o_m_tvalid && !res_granted, res_wait >= MIN_WAIT_US, "refused take below minimum wait")

endmodule

bind token_bucket_limiter_core tbkt_checker u_tbkt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
